[src/sqlis_pkg.sv]
package sqlis_pkg;

	// Window geometry: the history bytes plus the new byte form one span
	localparam int WIN_DEPTH    = 17;
	localparam int SPAN         = WIN_DEPTH + 1;
	localparam int NEEDLE_COUNT = 21;
	localparam int LEN_W        = $clog2(SPAN + 1);

	// Risk level codes
	typedef enum logic [1:0] {
		RISK_LOW      = 2'd0,
		RISK_MEDIUM   = 2'd1,
		RISK_HIGH     = 2'd2,
		RISK_CRITICAL = 2'd3
	} risk_t;

	// Byte span: index 0 is the newest byte, higher indexes are older
	typedef logic [SPAN-1:0][7:0] span_t;
	typedef logic [WIN_DEPTH-1:0][7:0] window_t;
	typedef logic [NEEDLE_COUNT-1:0] mask_t;

	// Needle text, right-justified: byte 0 holds the final character
	localparam span_t NEEDLE_TEXT [NEEDLE_COUNT] = '{
		"or '1'='1'", "union select", ";drop", ";truncate", ";alter",
		";create", "exec(", " xp_", "sleep(", "benchmark(",
		"waitfor delay", "into outfile", {"load", "_file("}, "/*", "--",
		"#", {"information", "_schema"}, {"pg", "_catalog"}, "char(", "concat(",
		"0x"
	};

	localparam logic [LEN_W-1:0] NEEDLE_LEN [NEEDLE_COUNT] = '{
		LEN_W'(10), LEN_W'(12), LEN_W'(5), LEN_W'(9), LEN_W'(6),
		LEN_W'(7), LEN_W'(5), LEN_W'(4), LEN_W'(6), LEN_W'(10),
		LEN_W'(13), LEN_W'(12), LEN_W'(10), LEN_W'(2), LEN_W'(2),
		LEN_W'(1), LEN_W'(18), LEN_W'(10), LEN_W'(5), LEN_W'(7),
		LEN_W'(2)
	};

	localparam risk_t NEEDLE_LEVEL [NEEDLE_COUNT] = '{
		RISK_CRITICAL, RISK_CRITICAL, RISK_CRITICAL, RISK_CRITICAL,
		RISK_CRITICAL, RISK_CRITICAL, RISK_CRITICAL,
		RISK_HIGH, RISK_HIGH, RISK_HIGH, RISK_HIGH, RISK_HIGH, RISK_HIGH,
		RISK_MEDIUM, RISK_MEDIUM, RISK_MEDIUM, RISK_MEDIUM, RISK_MEDIUM,
		RISK_MEDIUM,
		RISK_LOW, RISK_LOW
	};

	// Result of one scanned string
	typedef struct packed {
		risk_t risk_level;
		mask_t found_mask;
	} result_t;

endpackage

[src/sqlis_match.sv]
module sqlis_match
	import sqlis_pkg::*;
(
	input  span_t span,
	output mask_t hit
);

	// Compare the tail of the span against every needle in parallel
	always_comb begin
		for (int k = 0; k < NEEDLE_COUNT; k++) begin
			hit[k] = 1'b1;
			for (int j = 0; j < SPAN; j++) begin
				if ((LEN_W'(j) < NEEDLE_LEN[k]) && (span[j] != NEEDLE_TEXT[k][j])) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

endmodule

[src/sqlis_risk.sv]
module sqlis_risk
	import sqlis_pkg::*;
(
	input  mask_t mask,
	output risk_t level
);

	logic [3:0] level_seen;

	// Gather which levels are present
	always_comb begin
		level_seen = '0;
		for (int k = 0; k < NEEDLE_COUNT; k++) begin
			if (mask[k]) begin
				level_seen[NEEDLE_LEVEL[k]] = 1'b1;
			end
		end
	end

	// Pick the highest level present
	always_comb begin
		priority if (level_seen[RISK_CRITICAL]) begin
			level = RISK_CRITICAL;
		end else if (level_seen[RISK_HIGH]) begin
			level = RISK_HIGH;
		end else if (level_seen[RISK_MEDIUM]) begin
			level = RISK_MEDIUM;
		end else begin
			level = RISK_LOW;
		end
	end

endmodule

[src/sql_injection_pattern_scanner_core.sv]
// Query string pattern scanner.
// Input stream: one byte of the query string per transaction on s_axis, with
// s_axis_tlast on the final byte of each string. A zero byte ends the string
// content; bytes after it up to the tlast transaction are ignored.
// Output stream: one transaction on m_axis per string, issued for the tlast
// input, carrying the 21-bit found mask and the highest risk level.
// Throughput: one byte per cycle while no tlast byte waits for the result
// register; the parallel compare of the 18-byte span against all needles
// is combinational between the input and result registers. A tlast byte
// moves from the input register to the result register once that is free.
// Reset: arst_n clears the history window, the found bits, the halt flag and
// both valid flags; the block starts a fresh string afterwards.
// Stall: the result register holds its transaction until m_axis_tready.
// Bytes that are not last keep flowing while a result waits; a tlast byte
// waits in the input register until the result register is free, and
// s_axis_tready drops only then.
module sql_injection_pattern_scanner_core
	import sqlis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [20:0] found_mask, [22:21] risk_level, [23] zero
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [7:0] ch_fold;
	logic       advance;
	logic       scan;
	logic       out_load;

	window_t window_q;
	mask_t   seen_q;
	logic    halted_q;
	mask_t   seen_next;
	span_t   span;
	mask_t   hit;
	risk_t   level;

	result_t result_q;
	logic    out_valid_q;

	// Fold ASCII upper case to lower case
	always_comb begin
		if (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5a) begin
			ch_fold = s_axis_tdata | 8'h20;
		end else begin
			ch_fold = s_axis_tdata;
		end
	end

	// Hold a last byte until the result register can take it
	assign advance       = valid_s1 && !(last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign out_load      = advance && last_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= ch_fold;
			last_s1 <= s_axis_tlast;
		end
	end

	// Build the span: new byte first, then the history newest to oldest
	assign span = {window_q, byte_s1};
	assign scan = !halted_q && (byte_s1 != 8'h00);

	sqlis_match u_match (
		.span (span),
		.hit  (hit)
	);

	assign seen_next = seen_q | (scan ? hit : '0);

	sqlis_risk u_risk (
		.mask  (seen_next),
		.level (level)
	);

	// Scan state: advance the window, collect found bits, halt on a zero byte, clear on last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			halted_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				window_q <= '0;
				seen_q   <= '0;
				halted_q <= 1'b0;
			end else if (scan) begin
				window_q <= {window_q[WIN_DEPTH-2:0], byte_s1};
				seen_q   <= seen_next;
			end else if (!halted_q) begin
				halted_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.found_mask <= seen_next;
			result_q.risk_level <= level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, result_q};

	// Never overwrite a result that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten while stalled");

	// State returns to reset after the last byte of a string
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (seen_q == '0 && !halted_q && window_q == '0))
		else $error("scan state not cleared after end of string");

	// A halted string stays halted until its last byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && !(advance && last_s1)) |=> halted_q)
		else $error("halt flag dropped inside a string");

	// A critical needle always reports critical risk
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.found_mask[6:0] != '0)) |->
		(result_q.risk_level == RISK_CRITICAL))
		else $error("risk level below critical for a critical needle");

	// An empty mask reports low risk
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.found_mask == '0)) |-> (result_q.risk_level == RISK_LOW))
		else $error("nonzero risk level with no needle found");

endmodule
